// File: hdl/wcn_pkg.sv
// Shared types and constants for the 2D Worley cell noise block.
`default_nettype none

package wcn_pkg;

  // Coordinate and result widths.
  localparam int COORD_W = 32;
  localparam int OUT_W = 20;
  localparam int FRAC_BITS_DEFAULT = 16;

  // Cell hash constants.
  localparam logic [COORD_W-1:0] HASH_MUL_X = 32'd73856093;
  localparam logic [COORD_W-1:0] HASH_MUL_Y = 32'd19349663;
  localparam int HASH_SHIFT = 13;
  localparam int HASH_FRAC_BITS = 24;

  // Number of neighbor cells searched and pipeline registers in each of them.
  localparam int NCELL = 9;
  localparam int CELL_STAGES = 5;

  // Integer cell of the sample point, carried down the chain.
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } wcn_cell_t;

endpackage

`default_nettype wire

// File: hdl/wcn_cell.sv
// One link of the chain: distance to the feature point of one neighbor cell, folded into the running minimum.
`default_nettype none

module wcn_cell
  import wcn_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
  parameter int OX = 0,
  parameter int OY = 0
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  wcn_cell_t                  in_cell,
  input  wire  [FRAC_BITS-1:0]       in_fx,
  input  wire  [FRAC_BITS-1:0]       in_fy,
  input  wire  [2*FRAC_BITS+2:0]     in_best,
  output logic                       out_valid,
  output wcn_cell_t                  out_cell,
  output logic [FRAC_BITS-1:0]       out_fx,
  output logic [FRAC_BITS-1:0]       out_fy,
  output logic [2*FRAC_BITS+2:0]     out_best
);

  localparam int DW = FRAC_BITS + 2;
  localparam int SQW = 2 * FRAC_BITS + 2;
  localparam int SW = 2 * FRAC_BITS + 3;
  localparam logic [COORD_W-1:0] OX_W = COORD_W'(OX);
  localparam logic [COORD_W-1:0] OY_W = COORD_W'(OY);
  localparam logic signed [DW-1:0] OX_BASE = DW'(OX * (2 ** FRAC_BITS));
  localparam logic signed [DW-1:0] OY_BASE = DW'(OY * (2 ** FRAC_BITS));

  // Stage valid bits.
  logic a_valid, b_valid, c_valid, d_valid;

  // Stage payload.
  wcn_cell_t a_cell, b_cell, c_cell, d_cell;
  logic [FRAC_BITS-1:0] a_fx, a_fy, b_fx, b_fy, c_fx, c_fy, d_fx, d_fy;
  logic [SW-1:0] a_best, b_best, c_best, d_best;
  logic [COORD_W-1:0] a_nx, a_ny, a_nx1, a_ny1;
  logic [COORD_W-1:0] b_hx_a, b_hx_b, b_hy_a, b_hy_b;
  logic signed [DW-1:0] c_dx, c_dy;
  logic [SQW-1:0] d_sqx, d_sqy;

  // Combinational values between stages.
  logic [COORD_W-1:0] hx_mix, hy_mix, hx, hy;
  logic [FRAC_BITS-1:0] off_x, off_y;
  logic signed [DW-1:0] dx_next, dy_next;
  logic signed [2*DW-1:0] sqx_full, sqy_full;
  logic [SW-1:0] dist_sum, best_next;

  // Hash mixing and feature point offsets.
  assign hx_mix = b_hx_a ^ b_hx_b;
  assign hy_mix = b_hy_a ^ b_hy_b;
  assign hx = hx_mix ^ (hx_mix >> HASH_SHIFT);
  assign hy = hy_mix ^ (hy_mix >> HASH_SHIFT);
  assign off_x = hx[HASH_FRAC_BITS-1 -: FRAC_BITS];
  assign off_y = hy[HASH_FRAC_BITS-1 -: FRAC_BITS];

  // Per-axis difference from the sample to the feature point.
  assign dx_next = OX_BASE + $signed({2'b00, off_x}) - $signed({2'b00, b_fx});
  assign dy_next = OY_BASE + $signed({2'b00, off_y}) - $signed({2'b00, b_fy});

  // Squares of the differences; both are below four in fixed point.
  assign sqx_full = c_dx * c_dx;
  assign sqy_full = c_dy * c_dy;

  // Squared distance and running minimum.
  assign dist_sum = {1'b0, d_sqx} + {1'b0, d_sqy};
  assign best_next = (dist_sum < d_best) ? dist_sum : d_best;

  // Valid bits for every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      out_valid <= d_valid;
    end
  end

  // Payload pipeline: neighbor cell, hash products, differences, squares, minimum.
  always_ff @(posedge clk) begin
    a_cell <= in_cell;
    a_fx <= in_fx;
    a_fy <= in_fy;
    a_best <= in_best;
    a_nx <= in_cell.cx + OX_W;
    a_ny <= in_cell.cy + OY_W;
    a_nx1 <= in_cell.cx + OX_W + 32'd1;
    a_ny1 <= in_cell.cy + OY_W + 32'd1;

    b_cell <= a_cell;
    b_fx <= a_fx;
    b_fy <= a_fy;
    b_best <= a_best;
    b_hx_a <= a_nx * HASH_MUL_X;
    b_hx_b <= a_ny * HASH_MUL_Y;
    b_hy_a <= a_nx1 * HASH_MUL_X;
    b_hy_b <= a_ny1 * HASH_MUL_Y;

    c_cell <= b_cell;
    c_fx <= b_fx;
    c_fy <= b_fy;
    c_best <= b_best;
    c_dx <= dx_next;
    c_dy <= dy_next;

    d_cell <= c_cell;
    d_fx <= c_fx;
    d_fy <= c_fy;
    d_best <= c_best;
    d_sqx <= sqx_full[SQW-1:0];
    d_sqy <= sqy_full[SQW-1:0];

    out_cell <= d_cell;
    out_fx <= d_fx;
    out_fy <= d_fy;
    out_best <= best_next;
  end

endmodule

`default_nettype wire

// File: hdl/worley_cell_noise_2d_top.sv
// Top level of the 2D Worley cell noise block: input split, chain of nine cells, result register.
//
// A sample point is taken at every clock edge where start is high; busy is always low,
// so one point per clock is sustained indefinitely. The result appears on
// nearest_dist_sq with done high for exactly one cycle, in the same order as the
// points went in. The path holds 5 * 9 + 1 = 46 registers: the row of nine neighbor
// cells, each a five-register pipeline (neighbor add, hash multiply, hash mix and
// difference, square, add and minimum), followed by the output register. The
// receiver cannot stall the block and must take every result in the cycle it is shown.
`default_nettype none

module worley_cell_noise_2d_top
  import wcn_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  output logic                      busy,
  input  wire  signed [COORD_W-1:0] point_x,
  input  wire  signed [COORD_W-1:0] point_y,
  output logic                      done,
  output logic [OUT_W-1:0]          nearest_dist_sq
);

  localparam int SW = 2 * FRAC_BITS + 3;
  localparam int LATENCY = CELL_STAGES * NCELL + 1;

  // Links of the chain; index zero is the input side.
  logic                 chain_valid [0:NCELL];
  wcn_cell_t            chain_cell  [0:NCELL];
  logic [FRAC_BITS-1:0] chain_fx    [0:NCELL];
  logic [FRAC_BITS-1:0] chain_fy    [0:NCELL];
  logic [SW-1:0]        chain_best  [0:NCELL];

  logic [SW+OUT_W-1:0]  best_ext;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Split the point into its floor cell and fraction; the minimum starts at all ones.
  assign chain_valid[0] = start & ~busy;
  assign chain_cell[0].cx = {{FRAC_BITS{point_x[COORD_W-1]}}, point_x[COORD_W-1:FRAC_BITS]};
  assign chain_cell[0].cy = {{FRAC_BITS{point_y[COORD_W-1]}}, point_y[COORD_W-1:FRAC_BITS]};
  assign chain_fx[0] = point_x[FRAC_BITS-1:0];
  assign chain_fy[0] = point_y[FRAC_BITS-1:0];
  assign chain_best[0] = '1;

  // One cell for each of the 3x3 neighbor offsets.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    wcn_cell #(
      .FRAC_BITS(FRAC_BITS),
      .OX(k / 3 - 1),
      .OY(k % 3 - 1)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .in_valid(chain_valid[k]),
      .in_cell(chain_cell[k]),
      .in_fx(chain_fx[k]),
      .in_fy(chain_fy[k]),
      .in_best(chain_best[k]),
      .out_valid(chain_valid[k+1]),
      .out_cell(chain_cell[k+1]),
      .out_fx(chain_fx[k+1]),
      .out_fy(chain_fy[k+1]),
      .out_best(chain_best[k+1])
    );
  end

  // Drop the extra fractional bits and keep the low result bits.
  assign best_ext = {{OUT_W{1'b0}}, chain_best[NCELL]};

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_valid[NCELL];
    end
  end

  // Result value.
  always_ff @(posedge clk) begin
    nearest_dist_sq <= best_ext[FRAC_BITS +: OUT_W];
  end

  // A result only follows a transaction taken the fixed latency earlier.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done without a matching transaction");

  // After the first cell the running minimum holds a real distance.
  a_first_min: assert property (@(posedge clk) disable iff (rst)
    chain_valid[1] |-> (chain_best[1] != {SW{1'b1}}))
    else $error("running minimum not replaced by the first cell");

  // The minimum never grows across the last cell of the chain.
  a_min_order: assert property (@(posedge clk) disable iff (rst)
    chain_valid[NCELL] |-> (chain_best[NCELL] <= $past(chain_best[NCELL-1], CELL_STAGES)))
    else $error("running minimum grew in the last cell");

endmodule

`default_nettype wire
